FILE: rtl/rational_arithmetic_unit_macros.svh
// Assertion macros for the rational arithmetic unit.
// Used by the top level only; needs no other file.
`ifndef RATIONAL_ARITHMETIC_UNIT_MACROS_SVH
`define RATIONAL_ARITHMETIC_UNIT_MACROS_SVH

// Implication checked on every rising clock edge outside reset.
`define RAU_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication checked outside reset.
`define RAU_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

FILE: rtl/rau_pkg.sv
// Shared types and constants for the rational arithmetic unit.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package rau_pkg;
  localparam int WORD_BITS_DEF = 32;

  typedef enum logic [3:0] {
    FN_ADD = 4'd0, FN_SUB = 4'd1, FN_MUL = 4'd2, FN_DIV = 4'd3,
    FN_EQ = 4'd4, FN_GT = 4'd5, FN_LT = 4'd6, FN_GE = 4'd7,
    FN_LE = 4'd8, FN_NE = 4'd9
  } func_t;

  typedef enum logic [1:0] {
    ST_OK = 2'd0, ST_ZDEN = 2'd1, ST_OVF = 2'd2
  } status_t;

  // Kind of job handed from front to back.
  typedef enum logic [1:0] {
    JOB_DIRECT = 2'd0,  // result already known
    JOB_ARITH  = 2'd1   // needs gcd reduction
  } job_t;

  typedef enum logic [2:0] {
    BK_IDLE, BK_MUL, BK_SUM, BK_GCD, BK_DIVN, BK_DIVD, BK_CHECK, BK_OUT
  } bk_state_t;

  typedef enum logic [1:0] {
    FR_IDLE, FR_MUL, FR_CMP
  } fr_state_t;
endpackage
`default_nettype wire

FILE: rtl/rational_arithmetic_unit.sv
// Rational arithmetic unit, top level: front end, job queue, back end.
// Depends on rau_pkg, rau_front, rau_queue, rau_back and the macro header.
//
// Usage: present func and two reduced fractions on in_* with in_valid; one
// result word leaves on out_* per input word, in order.
// Unused codes and comparisons with a zero denominator pass straight to the
// queue; other comparisons first form 33x33 cross products in the front
// end. All add/sub/mul/div words run in the back end: products, then, for
// a nonzero result denominator, a binary gcd (one step per cycle, data
// dependent), then two 64-step restoring divisions by the gcd.
// The back end handles one word at a time; a two-entry queue lets the front
// accept new words while the back is busy.
// Reset (rst_n low, synchronous) empties the queue and drops any result.
// A stall on out_ready holds the result register; the queue then fills
// and in_ready drops.
`timescale 1ns / 1ps
`default_nettype none
`include "rational_arithmetic_unit_macros.svh"
module rational_arithmetic_unit #(
  parameter int WORD_BITS = rau_pkg::WORD_BITS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [3:0]  in_func,
  input  wire logic [31:0] in_a_num,
  input  wire logic [30:0] in_a_den,
  input  wire logic [31:0] in_b_num,
  input  wire logic [30:0] in_b_den,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [31:0]      out_res_num,
  output logic [30:0]      out_res_den,
  output logic             out_truth,
  output logic [1:0]       out_status
);
  localparam int QW = 2 + 4 + 64 * 4 + 1 + 2;

  logic        q_push, q_full, q_pop, q_empty;
  logic [1:0]  w_kind, r_kind;
  logic [3:0]  w_func, r_func;
  logic [63:0] w_an, w_ad, w_bn, w_bd, r_an, r_ad, r_bn, r_bd;
  logic        w_truth, r_truth;
  logic [1:0]  w_status, r_status;

  // front: accept and classify
  rau_front #(.WORD_BITS(WORD_BITS)) u_front (
    .clk, .rst_n, .in_valid, .in_ready, .in_func, .in_a_num, .in_a_den,
    .in_b_num, .in_b_den, .q_push, .q_full, .q_kind(w_kind), .q_func(w_func),
    .q_an(w_an), .q_ad(w_ad), .q_bn(w_bn), .q_bd(w_bd), .q_truth(w_truth),
    .q_status(w_status)
  );

  // queue: hold jobs between the two halves
  rau_queue #(.DW(QW)) u_queue (
    .clk, .rst_n, .push(q_push),
    .wdata({w_kind, w_func, w_an, w_ad, w_bn, w_bd, w_truth, w_status}),
    .full(q_full), .pop(q_pop), .empty(q_empty),
    .rdata({r_kind, r_func, r_an, r_ad, r_bn, r_bd, r_truth, r_status})
  );

  // back: compute and drive the result register
  rau_back #(.WORD_BITS(WORD_BITS)) u_back (
    .clk, .rst_n, .q_empty, .q_pop, .q_kind(r_kind), .q_func(r_func),
    .q_an(r_an), .q_ad(r_ad), .q_bn(r_bn), .q_bd(r_bd), .q_truth(r_truth),
    .q_status(r_status), .out_valid, .out_ready, .out_res_num, .out_res_den,
    .out_truth, .out_status
  );

  `RAU_ASSERT_IMP(a_no_push_full, clk, rst_n, q_full, !q_push)
  `RAU_ASSERT_IMP(a_no_pop_empty, clk, rst_n, q_empty, !q_pop)
  `RAU_ASSERT_IMP(a_truth_ok, clk, rst_n, out_valid && out_truth, out_status == rau_pkg::ST_OK)
  `RAU_ASSERT_IMP(a_truth_den, clk, rst_n, out_valid && out_truth, out_res_den == 31'd0)
endmodule
`default_nettype wire

FILE: rtl/rau_front.sv
// Front end: accepts items, forms 64-bit cross products for comparisons,
// and queues jobs for the back end. Depends on rau_pkg.
`timescale 1ns / 1ps
`default_nettype none
module rau_front #(
  parameter int WORD_BITS = rau_pkg::WORD_BITS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [3:0]  in_func,
  input  wire logic [31:0] in_a_num,
  input  wire logic [30:0] in_a_den,
  input  wire logic [31:0] in_b_num,
  input  wire logic [30:0] in_b_den,
  // queue write side
  output logic             q_push,
  input  wire logic        q_full,
  output logic [1:0]       q_kind,
  output logic [3:0]       q_func,
  output logic [63:0]      q_an,
  output logic [63:0]      q_ad,
  output logic [63:0]      q_bn,
  output logic [63:0]      q_bd,
  output logic             q_truth,
  output logic [1:0]       q_status
);
  localparam int W = WORD_BITS;

  rau_pkg::fr_state_t st_r, st_nxt;
  logic [3:0]  func_r;
  logic signed [63:0] an_r, ad_r, bn_r, bd_r;
  logic signed [63:0] l_r, r_r;

  logic signed [63:0] an_x, bn_x, ad_x, bd_x;
  assign an_x = 64'(signed'(in_a_num[W-1:0]));
  assign bn_x = 64'(signed'(in_b_num[W-1:0]));
  assign ad_x = 64'(in_a_den[W-2:0]);
  assign bd_x = 64'(in_b_den[W-2:0]);

  logic acc;
  assign in_ready = (st_r == rau_pkg::FR_IDLE) && !q_full;
  assign acc = in_valid && in_ready;

  logic truth_c;
  always_comb begin
    unique case (rau_pkg::func_t'(func_r))
      rau_pkg::FN_EQ: truth_c = (l_r == r_r);
      rau_pkg::FN_GT: truth_c = (l_r > r_r);
      rau_pkg::FN_LT: truth_c = (l_r < r_r);
      rau_pkg::FN_GE: truth_c = (l_r >= r_r);
      rau_pkg::FN_LE: truth_c = (l_r <= r_r);
      default:        truth_c = (l_r != r_r);
    endcase
  end

  always_comb begin
    st_nxt   = st_r;
    q_push   = 1'b0;
    q_kind   = rau_pkg::JOB_DIRECT;
    q_func   = in_func;
    q_an     = an_x;
    q_ad     = ad_x;
    q_bn     = bn_x;
    q_bd     = bd_x;
    q_truth  = 1'b0;
    q_status = rau_pkg::ST_OK;
    unique case (st_r)
      rau_pkg::FR_IDLE: begin
        if (acc) begin
          if (in_func > rau_pkg::FN_NE) begin
            q_push = 1'b1;
          end else if (in_func >= rau_pkg::FN_EQ) begin
            if (ad_x == 0 || bd_x == 0) begin
              q_push   = 1'b1;
              q_status = rau_pkg::ST_ZDEN;
            end else begin
              st_nxt = rau_pkg::FR_MUL;
            end
          end else begin
            q_push = 1'b1;
            q_kind = rau_pkg::JOB_ARITH;
          end
        end
      end
      rau_pkg::FR_MUL: st_nxt = rau_pkg::FR_CMP;
      rau_pkg::FR_CMP: begin
        if (!q_full) begin
          q_push  = 1'b1;
          q_truth = truth_c;
          st_nxt  = rau_pkg::FR_IDLE;
        end
      end
      default: st_nxt = rau_pkg::FR_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= rau_pkg::FR_IDLE;
    end else begin
      st_r <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      func_r <= in_func;
      an_r <= an_x; ad_r <= ad_x; bn_r <= bn_x; bd_r <= bd_x;
    end
    if (st_r == rau_pkg::FR_MUL) begin
      l_r <= 64'(signed'(an_r[32:0]) * signed'({1'b0, bd_r[31:0]}));
      r_r <= 64'(signed'(bn_r[32:0]) * signed'({1'b0, ad_r[31:0]}));
    end
  end
endmodule
`default_nettype wire

FILE: rtl/rau_queue.sv
// Two-entry job queue between front and back end.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
module rau_queue #(
  parameter int DW = 8
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  wire logic [DW-1:0] wdata,
  output logic               full,
  input  wire logic          pop,
  output logic               empty,
  output logic [DW-1:0]      rdata
);
  logic [DW-1:0] mem_r [2];
  logic wp_r, rp_r;
  logic [1:0] cnt_r;

  assign full  = (cnt_r == 2'd2);
  assign empty = (cnt_r == 2'd0);
  assign rdata = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0; rp_r <= 1'b0; cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= wdata;
  end
endmodule
`default_nettype wire

FILE: rtl/rau_back.sv
// Back end: cross products, binary gcd, restoring divisions,
// range check, and the output register. Depends on rau_pkg.
`timescale 1ns / 1ps
`default_nettype none
module rau_back #(
  parameter int WORD_BITS = rau_pkg::WORD_BITS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        q_empty,
  output logic             q_pop,
  input  wire logic [1:0]  q_kind,
  input  wire logic [3:0]  q_func,
  input  wire logic [63:0] q_an,
  input  wire logic [63:0] q_ad,
  input  wire logic [63:0] q_bn,
  input  wire logic [63:0] q_bd,
  input  wire logic        q_truth,
  input  wire logic [1:0]  q_status,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [31:0]      out_res_num,
  output logic [30:0]      out_res_den,
  output logic             out_truth,
  output logic [1:0]       out_status
);
  localparam int W = WORD_BITS;
  localparam logic [63:0] POS_LIM = (64'd1 << (W - 1)) - 64'd1;
  localparam logic [63:0] NEG_LIM = 64'd1 << (W - 1);

  rau_pkg::bk_state_t st_r, st_nxt;
  logic [3:0]  func_r;
  logic signed [63:0] an_r, ad_r, bn_r, bd_r;
  logic signed [63:0] p1_r, p2_r, p3_r;
  logic [63:0] nm_r, dm_r, gx_r, gy_r;
  logic [5:0]  gk_r;
  logic neg_r;
  logic [63:0] quo_r, rem_r, num_sh_r;
  logic [6:0]  cnt_r;
  logic [63:0] qn_r;
  logic        ov_r;
  logic [31:0] rn_r;
  logic [30:0] rd_r;
  logic        rt_r;
  logic [1:0]  rs_r;
  // staged arithmetic result, moved to the output register in BK_OUT
  logic [31:0] sn_r;
  logic [30:0] sd_r;
  logic [1:0]  ss_r;

  assign out_valid   = ov_r;
  assign out_res_num = rn_r;
  assign out_res_den = rd_r;
  assign out_truth   = rt_r;
  assign out_status  = rs_r;

  logic out_free;
  assign out_free = !ov_r || out_ready;

  // signed 64 sum and magnitudes
  logic signed [63:0] n_c, d_c;
  always_comb begin
    unique case (rau_pkg::func_t'(func_r))
      rau_pkg::FN_ADD: begin n_c = p1_r + p2_r; d_c = p3_r; end
      rau_pkg::FN_SUB: begin n_c = p1_r - p2_r; d_c = p3_r; end
      rau_pkg::FN_MUL: begin n_c = p1_r;        d_c = p3_r; end
      default:         begin n_c = p1_r;        d_c = p2_r; end
    endcase
  end

  // restoring divide step: num_sh_r by divisor gx_r
  logic [64:0] trial;
  logic [63:0] rem_sh;
  assign rem_sh = {rem_r[62:0], num_sh_r[63]};
  assign trial  = {1'b0, rem_sh} - {1'b0, gx_r};

  logic [63:0] gxy, gyx;
  assign gxy = gx_r - gy_r;
  assign gyx = gy_r - gx_r;

  always_comb begin
    st_nxt = st_r;
    q_pop  = 1'b0;
    unique case (st_r)
      rau_pkg::BK_IDLE:
        if (!q_empty) begin
          if (q_kind == rau_pkg::JOB_ARITH) begin
            q_pop = 1'b1; st_nxt = rau_pkg::BK_MUL;
          end else if (out_free) begin
            q_pop = 1'b1;
          end
        end
      rau_pkg::BK_MUL:  st_nxt = rau_pkg::BK_SUM;
      rau_pkg::BK_SUM:  st_nxt = (d_c == 0) ? rau_pkg::BK_OUT : rau_pkg::BK_GCD;
      rau_pkg::BK_GCD:  if (gx_r == 0 || gy_r == 0) st_nxt = rau_pkg::BK_DIVN;
      rau_pkg::BK_DIVN: if (cnt_r == 7'd63) st_nxt = rau_pkg::BK_DIVD;
      rau_pkg::BK_DIVD: if (cnt_r == 7'd63) st_nxt = rau_pkg::BK_CHECK;
      rau_pkg::BK_CHECK: st_nxt = rau_pkg::BK_OUT;
      rau_pkg::BK_OUT:  if (out_free) st_nxt = rau_pkg::BK_IDLE;
      default: st_nxt = rau_pkg::BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= rau_pkg::BK_IDLE;
      ov_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (out_ready) ov_r <= 1'b0;
      if (st_r == rau_pkg::BK_IDLE && q_pop && q_kind != rau_pkg::JOB_ARITH) ov_r <= 1'b1;
      if (st_r == rau_pkg::BK_OUT && out_free) ov_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    unique case (st_r)
      rau_pkg::BK_IDLE: begin
        func_r <= q_func;
        an_r <= q_an; ad_r <= q_ad; bn_r <= q_bn; bd_r <= q_bd;
        if (q_pop && q_kind != rau_pkg::JOB_ARITH) begin
          rn_r <= '0; rd_r <= '0; rt_r <= q_truth; rs_r <= q_status;
        end
      end
      rau_pkg::BK_MUL: begin
        // operands fit 33 signed bits, so each product is at most 33x33
        p1_r <= 64'(signed'(an_r[32:0]) * signed'((func_r == 4'(rau_pkg::FN_MUL))
                ? bn_r[32:0] : bd_r[32:0]));
        p2_r <= 64'(signed'((func_r == 4'(rau_pkg::FN_DIV)) ? ad_r[32:0] : bn_r[32:0])
                * signed'((func_r == 4'(rau_pkg::FN_DIV)) ? bn_r[32:0] : ad_r[32:0]));
        p3_r <= 64'(signed'(ad_r[32:0]) * signed'(bd_r[32:0]));
      end
      rau_pkg::BK_SUM: begin
        neg_r <= ((n_c < 0) != (d_c < 0)) && (n_c != 0);
        nm_r  <= n_c[63] ? 64'(-n_c) : 64'(n_c);
        dm_r  <= d_c[63] ? 64'(-d_c) : 64'(d_c);
        gx_r  <= n_c[63] ? 64'(-n_c) : 64'(n_c);
        gy_r  <= d_c[63] ? 64'(-d_c) : 64'(d_c);
        gk_r  <= '0;
        sn_r <= '0; sd_r <= '0; ss_r <= rau_pkg::ST_ZDEN;
      end
      rau_pkg::BK_GCD: begin
        // Binary gcd: drop shared factors of two, halve even values,
        // subtract and halve when both are odd; restore the shared factor
        // once one side reaches zero
        if (gx_r == 0 || gy_r == 0) begin
          gx_r <= (gx_r | gy_r) << gk_r;
          gy_r <= '0;
        end else if (!gx_r[0] && !gy_r[0]) begin
          gx_r <= gx_r >> 1; gy_r <= gy_r >> 1; gk_r <= gk_r + 6'd1;
        end else if (!gx_r[0]) begin
          gx_r <= gx_r >> 1;
        end else if (!gy_r[0]) begin
          gy_r <= gy_r >> 1;
        end else if (gx_r >= gy_r) begin
          gx_r <= gxy >> 1;
        end else begin
          gy_r <= gyx >> 1;
        end
        cnt_r <= '0; rem_r <= '0; num_sh_r <= nm_r;
      end
      rau_pkg::BK_DIVN, rau_pkg::BK_DIVD: begin
        num_sh_r <= {num_sh_r[62:0], 1'b0};
        if (!trial[64]) begin
          rem_r <= trial[63:0]; quo_r <= {quo_r[62:0], 1'b1};
        end else begin
          rem_r <= rem_sh; quo_r <= {quo_r[62:0], 1'b0};
        end
        cnt_r <= cnt_r + 7'd1;
        if (cnt_r == 7'd63) begin
          cnt_r <= '0; rem_r <= '0; num_sh_r <= dm_r;
          if (st_r == rau_pkg::BK_DIVN) qn_r <= {quo_r[62:0], !trial[64]};
        end
      end
      rau_pkg::BK_CHECK: begin
        if (quo_r > POS_LIM || (neg_r ? qn_r > NEG_LIM : qn_r > POS_LIM)) begin
          sn_r <= '0; sd_r <= '0; ss_r <= rau_pkg::ST_OVF;
        end else begin
          sn_r <= neg_r ? 32'(64'(-qn_r)) : 32'(qn_r);
          sd_r <= 31'(quo_r);
          ss_r <= rau_pkg::ST_OK;
        end
      end
      rau_pkg::BK_OUT: begin
        // load the output register only once the previous word has left
        if (out_free) begin
          rn_r <= sn_r; rd_r <= sd_r; rt_r <= 1'b0; rs_r <= ss_r;
        end
      end
      default: ;
    endcase
  end
endmodule
`default_nettype wire

FILE: test/tb_rational_arithmetic_unit.sv
// Self-checking testbench for rational_arithmetic_unit: directed and random
// fraction words, random idling on both sides, in-order result scoreboard.
// Depends on rau_pkg and the RTL of the unit.
`timescale 1ns / 1ps
module tb_rational_arithmetic_unit;

  typedef struct packed {
    logic [3:0]  func;
    logic [31:0] a_num;
    logic [30:0] a_den;
    logic [31:0] b_num;
    logic [30:0] b_den;
  } frac_word_t;

  typedef struct packed {
    logic [31:0] num;
    logic [30:0] den;
    logic        truth;
    logic [1:0]  status;
  } frac_result_t;

  localparam longint POS_MAX  = 64'h7FFF_FFFF;
  localparam longint NEG_MAG  = 64'h8000_0000;
  localparam int     IDLE_MAX = 20000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [3:0]  in_func = '0;
  logic [31:0] in_a_num = '0;
  logic [30:0] in_a_den = '0;
  logic [31:0] in_b_num = '0;
  logic [30:0] in_b_den = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [31:0] out_res_num;
  logic [30:0] out_res_den;
  logic        out_truth;
  logic [1:0]  out_status;

  frac_word_t   pending_words[$];
  frac_result_t expected_results[$];
  int           words_sent = 0;
  int           results_seen = 0;
  int           mismatches = 0;
  int           arith_words = 0;
  int           compare_words = 0;
  bit           stim_done = 1'b0;

  rational_arithmetic_unit DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_func(in_func), .in_a_num(in_a_num), .in_a_den(in_a_den),
    .in_b_num(in_b_num), .in_b_den(in_b_den),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_res_num(out_res_num), .out_res_den(out_res_den),
    .out_truth(out_truth), .out_status(out_status)
  );

  always #5 clk = ~clk;

  // Exact rational result of one word, reduced by Euclid's gcd.
  function automatic frac_result_t reduce_fraction(frac_word_t w);
    longint an, ad, bn, bd, n, d, l, r;
    longint unsigned nm, dm, g, x, y, t;
    bit neg, holds;
    frac_result_t res;
    an = longint'($signed(w.a_num));
    ad = longint'({33'b0, w.a_den});
    bn = longint'($signed(w.b_num));
    bd = longint'({33'b0, w.b_den});
    res = '0;
    if (w.func > rau_pkg::FN_NE) return res;
    if (w.func >= rau_pkg::FN_EQ) begin
      if (ad == 0 || bd == 0) begin
        res.status = rau_pkg::ST_ZDEN;
        return res;
      end
      l = an * bd;
      r = bn * ad;
      case (rau_pkg::func_t'(w.func))
        rau_pkg::FN_EQ: holds = (l == r);
        rau_pkg::FN_GT: holds = (l > r);
        rau_pkg::FN_LT: holds = (l < r);
        rau_pkg::FN_GE: holds = (l >= r);
        rau_pkg::FN_LE: holds = (l <= r);
        default:        holds = (l != r);
      endcase
      res.truth = holds;
      return res;
    end
    case (rau_pkg::func_t'(w.func))
      rau_pkg::FN_ADD: begin n = an * bd + bn * ad; d = ad * bd; end
      rau_pkg::FN_SUB: begin n = an * bd - bn * ad; d = ad * bd; end
      rau_pkg::FN_MUL: begin n = an * bn; d = ad * bd; end
      default:         begin n = an * bd; d = ad * bn; end
    endcase
    if (d == 0) begin
      res.status = rau_pkg::ST_ZDEN;
      return res;
    end
    neg = ((n < 0) != (d < 0)) && n != 0;
    nm = (n < 0) ? -n : n;
    dm = (d < 0) ? -d : d;
    x = nm;
    y = dm;
    while (y != 0) begin
      t = x % y;
      x = y;
      y = t;
    end
    g = x;
    nm = nm / g;
    dm = dm / g;
    if (dm > POS_MAX || (neg ? nm > NEG_MAG : nm > POS_MAX)) begin
      res.status = rau_pkg::ST_OVF;
      return res;
    end
    res.num = neg ? 32'(-nm) : 32'(nm);
    res.den = 31'(dm);
    res.status = rau_pkg::ST_OK;
    return res;
  endfunction

  function automatic frac_word_t make_word(logic [3:0] f, logic [31:0] an, logic [30:0] ad,
                                           logic [31:0] bn, logic [30:0] bd);
    frac_word_t w;
    w.func = f; w.a_num = an; w.a_den = ad; w.b_num = bn; w.b_den = bd;
    return w;
  endfunction

  // Small signed value, so reduced results often fit and cancel.
  function automatic logic [31:0] small_num();
    return 32'($signed($urandom_range(0, 128)) - 64);
  endfunction

  // Random word: comparisons over the full range, arithmetic on small
  // operands, on full-range operands, and on large values times or over +-1.
  function automatic frac_word_t random_word();
    int sel;
    logic [31:0] big;
    sel = $urandom_range(0, 99);
    if (sel < 45) begin
      return make_word(4'($urandom_range(rau_pkg::FN_EQ, rau_pkg::FN_NE)), $urandom,
                       31'($urandom_range(1, 32'h7FFF_FFFF)), $urandom,
                       31'($urandom_range(1, 32'h7FFF_FFFF)));
    end else if (sel < 50) begin
      // Equal cross products make eq/ge/le hold.
      big = 32'($urandom_range(1, 32'h3FFF_FFFF));
      return make_word(4'($urandom_range(rau_pkg::FN_EQ, rau_pkg::FN_NE)), big,
                       31'(big) | 31'h1, big, 31'(big) | 31'h1);
    end else if (sel < 78) begin
      return make_word(4'($urandom_range(rau_pkg::FN_ADD, rau_pkg::FN_DIV)), small_num(),
                       31'($urandom_range(1, 64)), small_num(),
                       31'($urandom_range(1, 64)));
    end else if (sel < 92) begin
      // Full-range operands: overflow, long gcd runs, stray zero denominators.
      return make_word(4'($urandom_range(rau_pkg::FN_ADD, rau_pkg::FN_DIV)), $urandom,
                       31'($urandom), $urandom, 31'($urandom));
    end else begin
      // Large numerator over a denominator of like size, times or over +-1.
      big = 32'($urandom_range(32'h4000_0000, 32'h7FFF_FFFF));
      return make_word($urandom_range(0, 1) ? rau_pkg::FN_MUL : rau_pkg::FN_DIV,
                       $urandom_range(0, 1) ? -big : big,
                       31'($urandom_range(32'h4000_0000, 32'h7FFF_FFFF)),
                       $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'd1, 31'd1);
    end
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Stimulus: directed corner words, then random words.
  initial begin
    // Arithmetic with zero results, signs and small operands.
    pending_words.push_back(make_word(rau_pkg::FN_ADD, 32'd1, 31'd2, 32'd1, 31'd2));
    pending_words.push_back(make_word(rau_pkg::FN_SUB, 32'd3, 31'd4, 32'd3, 31'd4));
    pending_words.push_back(make_word(rau_pkg::FN_MUL, -32'sd2, 31'd3, 32'd3, 31'd5));
    pending_words.push_back(make_word(rau_pkg::FN_DIV, 32'd1, 31'd3, -32'sd2, 31'd7));
    pending_words.push_back(make_word(rau_pkg::FN_MUL, 32'd0, 31'd1, 32'd5, 31'd7));
    // Division by zero numerator, and zero denominators given as input.
    pending_words.push_back(make_word(rau_pkg::FN_DIV, 32'd5, 31'd3, 32'd0, 31'd1));
    pending_words.push_back(make_word(rau_pkg::FN_ADD, 32'd1, 31'd0, 32'd1, 31'd2));
    pending_words.push_back(make_word(rau_pkg::FN_EQ, 32'd1, 31'd2, 32'd1, 31'd0));
    // Overflow: denominator past the positive limit.
    pending_words.push_back(make_word(rau_pkg::FN_MUL, 32'h7FFF_FFFF, 31'h4000_0000,
                                      32'd3, 31'd2));
    // Extremes passed through by multiplying with one or dividing by minus one.
    pending_words.push_back(make_word(rau_pkg::FN_MUL, 32'h8000_0001, 31'h7FFF_FFFF,
                                      32'd1, 31'd1));
    pending_words.push_back(make_word(rau_pkg::FN_DIV, 32'h7FFF_FFFF, 31'h7FFF_FFFE,
                                      32'hFFFF_FFFF, 31'd1));
    // Every comparison on extreme operands and on equal fractions.
    for (int f = rau_pkg::FN_EQ; f <= rau_pkg::FN_NE; f++) begin
      pending_words.push_back(make_word(4'(f), 32'h8000_0000, 31'h7FFF_FFFF,
                                        32'h7FFF_FFFF, 31'd1));
      pending_words.push_back(make_word(4'(f), 32'd6, 31'd4, 32'd3, 31'd2));
    end
    // Unused function codes.
    pending_words.push_back(make_word(4'd10, 32'd1, 31'd1, 32'd1, 31'd1));
    pending_words.push_back(make_word(4'd15, 32'hFFFF_FFFF, 31'h7FFF_FFFF, 32'd0, 31'd1));
    repeat (1100) pending_words.push_back(random_word());

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    wait (stim_done);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    $display("Covered %0d words: %0d arithmetic, %0d comparisons or unused codes.",
             words_sent, arith_words, compare_words);
    $display("Checked %0d results, %0d mismatching.", results_seen, mismatches);
    if (mismatches == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

  // Driver: hold each word until accepted, then advance after a random gap.
  int send_gap = 0;
  always @(posedge clk) begin
    frac_word_t w;
    if (rst_n && (!in_valid || in_ready)) begin
      if (send_gap > 0) begin
        send_gap <= send_gap - 1;
        in_valid <= 1'b0;
      end else if (pending_words.size() != 0) begin
        w = pending_words.pop_front();
        in_func <= w.func;
        in_a_num <= w.a_num;
        in_a_den <= w.a_den;
        in_b_num <= w.b_num;
        in_b_den <= w.b_den;
        in_valid <= 1'b1;
        send_gap <= pick_gap();
      end else begin
        in_valid <= 1'b0;
        if (!in_valid || in_ready) stim_done <= 1'b1;
      end
    end
  end

  // Receiver: random stalls, plus one long hold-off so the queue fills
  // and in_ready drops while the driver keeps offering words.
  int stall_left = 0;
  bit long_hold_done = 1'b0;
  always @(posedge clk) begin
    if (rst_n) begin
      if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        out_ready <= 1'b0;
      end else if (!long_hold_done && words_sent >= 300) begin
        long_hold_done <= 1'b1;
        stall_left <= 3000;
        out_ready <= 1'b0;
      end else begin
        stall_left <= pick_gap();
        out_ready <= 1'b1;
      end
    end
  end

  // Monitor: predict on each accepted word, check each accepted result.
  int idle_cycles = 0;
  always @(posedge clk) begin
    frac_word_t   w;
    frac_result_t want;
    bit           moved;
    moved = 1'b0;
    if (rst_n && in_valid && in_ready) begin
      w = make_word(in_func, in_a_num, in_a_den, in_b_num, in_b_den);
      expected_results.push_back(reduce_fraction(w));
      words_sent <= words_sent + 1;
      if (in_func <= rau_pkg::FN_DIV) arith_words <= arith_words + 1;
      else compare_words <= compare_words + 1;
      moved = 1'b1;
    end
    if (rst_n && out_valid && out_ready) begin
      moved = 1'b1;
      results_seen <= results_seen + 1;
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result num=%h den=%h truth=%b status=%0d", $time,
                 out_res_num, out_res_den, out_truth, out_status);
        mismatches <= mismatches + 1;
      end else begin
        want = expected_results.pop_front();
        if (out_res_num !== want.num || out_res_den !== want.den ||
            out_truth !== want.truth || out_status !== want.status) begin
          $display("%0t: expected num=%h den=%h truth=%b status=%0d", $time,
                   want.num, want.den, want.truth, want.status);
          $display("%0t: actual   num=%h den=%h truth=%b status=%0d", $time,
                   out_res_num, out_res_den, out_truth, out_status);
          mismatches <= mismatches + 1;
        end
      end
    end
    // Watchdog: drop the run if nothing moves for too long.
    if (moved || !rst_n) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_MAX) begin
      $display("%0t: timeout with %0d results outstanding", $time,
               expected_results.size());
      $display("Mismatches found");
      $finish;
    end
  end
endmodule
